// ----- design/fpoel_pkg.sv -----
`default_nettype none

package fpoel_pkg;

	// Fixed field widths of the command and response beats
	localparam int unsigned OP_W      = 2;
	localparam int unsigned POS_W     = 4;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned WORD_W    = 64;
	localparam int unsigned ENTRY_WORDS = 4;
	localparam int unsigned FLAT_W    = WORD_W * ENTRY_WORDS;
	localparam int unsigned CNT_W     = 4;

	// Default geometry of the pool
	localparam int unsigned POOL_SLOTS_DEF  = 9;
	localparam int unsigned ENTRY_BYTES_DEF = 32;

	typedef enum logic [OP_W-1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_VIEW = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [POS_W-1:0]  position;
		logic [WORD_W-1:0] entry_word0;
		logic [WORD_W-1:0] entry_word1;
		logic [WORD_W-1:0] entry_word2;
		logic [WORD_W-1:0] entry_word3;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   read_word0;
		logic [WORD_W-1:0]   read_word1;
		logic [WORD_W-1:0]   read_word2;
		logic [WORD_W-1:0]   read_word3;
	} rsp_t;

endpackage

`default_nettype wire

// ----- design/fixed_pool_ordered_entry_list.sv -----
`default_nettype none

// Ordered entry pool: holds up to POOL_SLOTS entries of ENTRY_BYTES bytes, newest at
// position 0. A command beat is taken on any cycle with start high (busy stays low, so
// one command per clock is sustained). Each command gives exactly one response beat,
// marked by done: the command register feeds the shift/select logic, which loads the
// response register at the next edge. The response is shown for one cycle only and
// cannot be stalled; the receiver must take it when done is high. Add cuts the entry
// at its first zero byte; view returns the stored entry, and every other case returns
// zero read words with the status code.
module fixed_pool_ordered_entry_list #(
	parameter int unsigned POOL_SLOTS  = fpoel_pkg::POOL_SLOTS_DEF,
	parameter int unsigned ENTRY_BYTES = fpoel_pkg::ENTRY_BYTES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire fpoel_pkg::cmd_t cmd,
	output logic                 done,
	output fpoel_pkg::rsp_t      rsp
);

	localparam int unsigned ROW_W = ENTRY_BYTES * 8;
	localparam int unsigned IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

	// Command stage
	logic            valid_s1;
	fpoel_pkg::cmd_t cmd_s1;

	// Pool rows and fill count
	logic [ROW_W-1:0]            ent_q [POOL_SLOTS];
	logic [ROW_W-1:0]            ent_d [POOL_SLOTS];
	logic [fpoel_pkg::CNT_W-1:0] cnt_q;

	// Decode and result
	logic                        is_add;
	logic                        is_del;
	logic                        is_view;
	logic                        full;
	logic                        hit;
	logic                        do_add;
	logic                        do_del;
	logic                        ent_we;
	logic [fpoel_pkg::FLAT_W-1:0] in_flat;
	logic [ROW_W-1:0]            trim_row;
	logic [fpoel_pkg::FLAT_W-1:0] rd_flat;
	fpoel_pkg::rsp_t             rsp_d;

	logic            done_q;
	fpoel_pkg::rsp_t rsp_q;

	// Every command is taken on arrival
	assign busy = 1'b0;

	// Capture the command beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	// Decode the held command
	assign is_add  = (cmd_s1.operation == fpoel_pkg::OP_ADD);
	assign is_del  = (cmd_s1.operation == fpoel_pkg::OP_DEL);
	assign is_view = (cmd_s1.operation == fpoel_pkg::OP_VIEW);
	assign full    = (cnt_q >= fpoel_pkg::CNT_W'(POOL_SLOTS));
	assign hit     = (fpoel_pkg::CNT_W'(cmd_s1.position) < cnt_q);
	assign do_add  = valid_s1 && is_add && !full;
	assign do_del  = valid_s1 && is_del && hit;
	assign ent_we  = do_add || do_del;

	// Cut the new entry at its first zero byte
	assign in_flat = {cmd_s1.entry_word3, cmd_s1.entry_word2,
		cmd_s1.entry_word1, cmd_s1.entry_word0};

	always_comb begin
		logic keep;
		keep     = 1'b1;
		trim_row = '0;
		for (int b = 0; b < ENTRY_BYTES; b++) begin
			keep = keep && (in_flat[b*8 +: 8] != 8'd0);
			trim_row[b*8 +: 8] = keep ? in_flat[b*8 +: 8] : 8'd0;
		end
	end

	// Next row value: shift back on add, close the gap on delete
	for (genvar g = 0; g < POOL_SLOTS; g++) begin : g_row
		logic [ROW_W-1:0] from_front;
		logic [ROW_W-1:0] from_back;

		if (g == 0) begin : g_head
			assign from_front = trim_row;
		end else begin : g_body
			assign from_front = ent_q[g-1];
		end

		if (g == POOL_SLOTS - 1) begin : g_tail
			assign from_back = ent_q[g];
		end else begin : g_mid
			assign from_back = ent_q[g+1];
		end

		assign ent_d[g] = do_add ? from_front :
			((fpoel_pkg::CNT_W'(g) >= fpoel_pkg::CNT_W'(cmd_s1.position)) ?
			from_back : ent_q[g]);

		always_ff @(posedge clk) begin
			if (ent_we) begin
				ent_q[g] <= ent_d[g];
			end
		end
	end

	// Track the number of held entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (do_add) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (do_del) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Select the viewed row and build the response
	always_comb begin
		rd_flat = '0;
		if (is_view && hit) begin
			rd_flat = fpoel_pkg::FLAT_W'(ent_q[cmd_s1.position[IDX_W-1:0]]);
		end
	end

	always_comb begin
		rsp_d.status = fpoel_pkg::ST_DONE;
		if (is_add && full) begin
			rsp_d.status = fpoel_pkg::ST_FULL;
		end else if ((is_del || is_view) && !hit) begin
			rsp_d.status = fpoel_pkg::ST_NONE;
		end
		rsp_d.read_word0 = rd_flat[0*fpoel_pkg::WORD_W +: fpoel_pkg::WORD_W];
		rsp_d.read_word1 = rd_flat[1*fpoel_pkg::WORD_W +: fpoel_pkg::WORD_W];
		rsp_d.read_word2 = rd_flat[2*fpoel_pkg::WORD_W +: fpoel_pkg::WORD_W];
		rsp_d.read_word3 = rd_flat[3*fpoel_pkg::WORD_W +: fpoel_pkg::WORD_W];
	end

	// Register the response beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	// Fill count never passes the pool size
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= fpoel_pkg::CNT_W'(POOL_SLOTS))
		else $error("entry count above pool size");

	// A full report leaves the pool at capacity
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (rsp_q.status == fpoel_pkg::ST_FULL)
		|-> cnt_q == fpoel_pkg::CNT_W'(POOL_SLOTS))
		else $error("full status with free slots");

	// A successful add grows the count by one
	a_add_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		do_add |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("add did not advance entry count");

	// Failed commands return zero read words
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (rsp_q.status != fpoel_pkg::ST_DONE)
		|-> (rsp_q.read_word0 == '0) && (rsp_q.read_word1 == '0) &&
		(rsp_q.read_word2 == '0) && (rsp_q.read_word3 == '0))
		else $error("read data on failed command");
`endif

endmodule

`default_nettype wire

// ----- sim/fixed_pool_ordered_entry_list_tb.sv -----
`timescale 1ns / 100ps

module fixed_pool_ordered_entry_list_tb;

	localparam int unsigned POOL_SLOTS   = fpoel_pkg::POOL_SLOTS_DEF;
	localparam int unsigned ENTRY_BYTES  = fpoel_pkg::ENTRY_BYTES_DEF;
	localparam logic [fpoel_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned RANDOM_BEATS = 1800;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_LIMIT  = 1000;
	localparam int unsigned TAIL_CYCLES  = 8;

	// Shadow copy of the pool plus the responses still owed by the block
	class entry_pool_scoreboard;
		logic [fpoel_pkg::FLAT_W-1:0] held [POOL_SLOTS];
		int unsigned                  held_count;
		fpoel_pkg::rsp_t              awaited [$];
		int unsigned                  errors;

		function new();
			held_count = 0;
			errors = 0;
		endfunction

		// Cut the entry at its first zero byte and drop bytes past the entry size
		function logic [fpoel_pkg::FLAT_W-1:0] trim(logic [fpoel_pkg::FLAT_W-1:0] raw);
			logic [fpoel_pkg::FLAT_W-1:0] kept;
			bit ended;
			kept = '0;
			ended = 1'b0;
			for (int b = 0; b < fpoel_pkg::FLAT_W / 8; b++) begin
				if (b >= ENTRY_BYTES || raw[b*8 +: 8] == 8'h00)
					ended = 1'b1;
				if (!ended)
					kept[b*8 +: 8] = raw[b*8 +: 8];
			end
			return kept;
		endfunction

		// Apply an accepted command beat to the shadow pool and queue its response
		function void note_command(fpoel_pkg::cmd_t c);
			fpoel_pkg::rsp_t r;
			r = '0;
			r.status = fpoel_pkg::ST_DONE;
			case (c.operation)
			fpoel_pkg::OP_ADD: begin
				if (held_count >= POOL_SLOTS) begin
					r.status = fpoel_pkg::ST_FULL;
				end else begin
					for (int i = int'(held_count); i > 0; i--)
						held[i] = held[i-1];
					held[0] = trim({c.entry_word3, c.entry_word2, c.entry_word1,
						c.entry_word0});
					held_count++;
				end
			end
			fpoel_pkg::OP_DEL: begin
				if (c.position >= held_count) begin
					r.status = fpoel_pkg::ST_NONE;
				end else begin
					for (int i = int'(c.position); i + 1 < int'(held_count); i++)
						held[i] = held[i+1];
					held_count--;
				end
			end
			fpoel_pkg::OP_VIEW: begin
				if (c.position >= held_count)
					r.status = fpoel_pkg::ST_NONE;
				else
					{r.read_word3, r.read_word2, r.read_word1, r.read_word0} =
						held[c.position];
			end
			default: begin
			end
			endcase
			awaited.insert(awaited.size(), r);
		endfunction

		function void compare_field(string field, logic [fpoel_pkg::WORD_W-1:0] want,
			logic [fpoel_pkg::WORD_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %h, got %h", field, want, got);
				errors++;
			end
		endfunction

		// Match a response beat against the oldest owed response
		function void check_response(fpoel_pkg::rsp_t got);
			fpoel_pkg::rsp_t want;
			if (awaited.size() == 0) begin
				$error("response beat with nothing outstanding: status %0d", got.status);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare_field("status", fpoel_pkg::WORD_W'(want.status),
				fpoel_pkg::WORD_W'(got.status));
			compare_field("read_word0", want.read_word0, got.read_word0);
			compare_field("read_word1", want.read_word1, got.read_word1);
			compare_field("read_word2", want.read_word2, got.read_word2);
			compare_field("read_word3", want.read_word3, got.read_word3);
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic            done;
	fpoel_pkg::cmd_t cmd;
	fpoel_pkg::rsp_t rsp;
	int unsigned     cycle_count = 0;

	entry_pool_scoreboard pool_sb;

	fixed_pool_ordered_entry_list #(
		.POOL_SLOTS(POOL_SLOTS),
		.ENTRY_BYTES(ENTRY_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Watch both handshakes at each edge: note the command first, then check
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				pool_sb.note_command(cmd);
			if (done)
				pool_sb.check_response(rsp);
		end
	end

	function automatic fpoel_pkg::cmd_t make_cmd(logic [fpoel_pkg::OP_W-1:0] op,
		int unsigned pos, logic [fpoel_pkg::FLAT_W-1:0] words);
		fpoel_pkg::cmd_t c;
		c.operation = op;
		c.position = fpoel_pkg::POS_W'(pos);
		{c.entry_word3, c.entry_word2, c.entry_word1, c.entry_word0} = words;
		return c;
	endfunction

	// All ones except one zero byte
	function automatic logic [fpoel_pkg::FLAT_W-1:0] with_zero_at(int unsigned b);
		logic [fpoel_pkg::FLAT_W-1:0] w;
		w = '1;
		w[b*8 +: 8] = 8'h00;
		return w;
	endfunction

	// Mostly nonzero bytes with one terminator somewhere; some fully random words
	function automatic logic [fpoel_pkg::FLAT_W-1:0] random_entry();
		logic [fpoel_pkg::FLAT_W-1:0] w;
		int unsigned kind;
		int unsigned cut;
		kind = $urandom_range(9);
		if (kind < 2) begin
			for (int i = 0; i < fpoel_pkg::ENTRY_WORDS; i++)
				w[i*fpoel_pkg::WORD_W +: fpoel_pkg::WORD_W] = {$urandom, $urandom};
		end else begin
			for (int b = 0; b < fpoel_pkg::FLAT_W / 8; b++)
				w[b*8 +: 8] = 8'($urandom_range(1, 255));
			if (kind < 8) begin
				cut = $urandom_range(0, fpoel_pkg::FLAT_W / 8 - 1);
				w[cut*8 +: 8] = 8'h00;
			end
		end
		return w;
	endfunction

	// Lean toward adds while filling, toward deletes while draining
	function automatic fpoel_pkg::cmd_t random_cmd(bit filling);
		fpoel_pkg::cmd_t c;
		int unsigned pick;
		int unsigned pos;
		pick = $urandom_range(99);
		if ($urandom_range(99) < 15)
			pos = $urandom_range(0, 15);
		else
			pos = $urandom_range(0, POOL_SLOTS - 1);
		if (pick < 4)
			c = make_cmd(OP_UNUSED, pos, random_entry());
		else if (pick < (filling ? 64 : 28))
			c = make_cmd(fpoel_pkg::OP_ADD, pos, random_entry());
		else if (pick < (filling ? 80 : 66))
			c = make_cmd(fpoel_pkg::OP_DEL, pos, random_entry());
		else
			c = make_cmd(fpoel_pkg::OP_VIEW, pos, random_entry());
		return c;
	endfunction

	// Present one command beat and hold it until the block takes it
	task automatic send_cmd(fpoel_pkg::cmd_t c, bit may_idle);
		int unsigned gap;
		gap = 0;
		if (may_idle && $urandom_range(99) < 14)
			gap = $urandom_range(1, 4);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		int unsigned waited;
		bit filling;
		bit may_idle;

		pool_sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty pool, unused opcode, then fill with boundary entries
		send_cmd(make_cmd(fpoel_pkg::OP_VIEW, 0, '1), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_DEL, 0, '1), 1'b1);
		send_cmd(make_cmd(OP_UNUSED, 15, '1), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_ADD, 15, '1), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_ADD, 0, '0), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_ADD, 7, with_zero_at(0)), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_ADD, 0, with_zero_at(31)), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_ADD, 0, with_zero_at(8)), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_ADD, 0, with_zero_at(7)), 1'b1);
		repeat (POOL_SLOTS - 6)
			send_cmd(make_cmd(fpoel_pkg::OP_ADD, 0, random_entry()), 1'b1);

		// Full pool, edges of the held range, then deletes at both ends
		send_cmd(make_cmd(fpoel_pkg::OP_ADD, 0, '1), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_VIEW, 0, '0), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_VIEW, POOL_SLOTS - 1, '0), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_VIEW, POOL_SLOTS, '0), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_VIEW, 15, '1), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_DEL, POOL_SLOTS - 1, '0), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_DEL, 0, '0), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_DEL, 15, '0), 1'b1);
		send_cmd(make_cmd(fpoel_pkg::OP_VIEW, 3, '0), 1'b1);

		// Random traffic swinging between full and empty; one stretch back to back
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			filling = ((n / 120) % 2) == 0;
			may_idle = !(n >= 700 && n < 1000);
			send_cmd(random_cmd(filling), may_idle);
		end
		start <= 1'b0;

		// Drain outstanding responses, then let the pipeline settle
		waited = 0;
		while (pool_sb.awaited.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pool_sb.awaited.size() != 0) begin
			$error("%0d responses never arrived", pool_sb.awaited.size());
			pool_sb.errors++;
		end

		if (pool_sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
